### src/gpa_pkg.sv
package gpa_pkg;

   // Configuration register indexes.
   localparam logic CSR_GRAV_CONST     = 1'b0;
   localparam logic CSR_SOFT_RADIUS_SQ = 1'b1;

   localparam int unsigned CSR_WIDTH  = 32;
   localparam int unsigned MASS_WIDTH = 32;

   localparam logic [CSR_WIDTH-1:0] GRAV_CONST_RESET     = 32'd65536000;
   localparam logic [CSR_WIDTH-1:0] SOFT_RADIUS_SQ_RESET = 32'd65536;

   // The cutoff is Q16.16 while r squared is Q32.32.
   localparam int unsigned SOFT_SHIFT = 16;

   // Fixed-point layout of the force path.
   localparam int unsigned GDIV_FRAC  = 62;   // unit vector component in Q.62
   localparam int unsigned G_WIDTH    = 63;   // unit component never exceeds 2^62
   localparam int unsigned Q_WIDTH    = 64;   // G times mass
   localparam int unsigned PROD_SHIFT = 38;   // drops q*g back to Q24.24 times r2
   localparam int unsigned PROD_WIDTH = 89;   // bits of q*g above the shift
   localparam int unsigned MUL_WIDTH  = 128;  // accumulator of the shift-add multiplier
   localparam int unsigned MUL_BWIDTH = 64;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_CMP,
      ST_SQRT,
      ST_QMUL,
      ST_AXIS,
      ST_GDIV,
      ST_PMUL,
      ST_MDIV,
      ST_ACC,
      ST_FIN
   } gpa_state_type;

   typedef struct packed {
      logic active;
      logic last;
   } gpa_flags_type;

endpackage

### src/gravity_pair_accel_accumulator.sv
// Channel   Direction  Handshake                   Moves
// req_*     in         req_valid / req_ready       one target/source pair request
// rsp_*     out        rsp_valid / rsp_ready       summed acceleration of one target
// csr_*     in         csr_we, no wait             grav_const, soft_radius_sq
//
// An absent or self pair goes straight from idle to the finish state in the back end, and a
// pair inside the cutoff only forms r squared and compares it. The time of a contributing
// pair is set by the bit-serial multiplier, square-root and divider that the back end
// steps through; an axis with zero difference skips its divisions.
// Reset is synchronous and clears the queue, the sequencer, the sums and the flag.
// A two-entry queue lets requests arrive while the back end is busy, and a result
// waits in the output register while the next pair is already being worked on.
module gravity_pair_accel_accumulator import gpa_pkg::*; #(
   parameter int unsigned POS_WIDTH = 32,
   parameter int unsigned ACC_WIDTH = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [POS_WIDTH-1:0] req_target_x,
   input  logic signed [POS_WIDTH-1:0] req_target_y,
   input  logic signed [POS_WIDTH-1:0] req_target_z,
   input  logic signed [POS_WIDTH-1:0] req_source_x,
   input  logic signed [POS_WIDTH-1:0] req_source_y,
   input  logic signed [POS_WIDTH-1:0] req_source_z,
   input  logic [MASS_WIDTH-1:0]       req_source_mass,
   input  logic                        req_source_present,
   input  logic                        req_is_self,
   input  logic                        req_last_pair,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [ACC_WIDTH-1:0] rsp_accel_x,
   output logic signed [ACC_WIDTH-1:0] rsp_accel_y,
   output logic signed [ACC_WIDTH-1:0] rsp_accel_z,
   output logic                        rsp_saturated,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [CSR_WIDTH-1:0]        csr_wdata
);

   // Configuration registers. The user must see that they are only written while the
   // block is idle, so the back end reads them directly; the block does not enforce it.
   logic [CSR_WIDTH-1:0] grav_const_ff, grav_const_in;
   logic [CSR_WIDTH-1:0] soft_radius_sq_ff, soft_radius_sq_in;

   always_comb begin
      grav_const_in     = grav_const_ff;
      soft_radius_sq_in = soft_radius_sq_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GRAV_CONST:     grav_const_in     = csr_wdata;
            CSR_SOFT_RADIUS_SQ: soft_radius_sq_in = csr_wdata;
            default: begin
               grav_const_in = grav_const_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_const_ff     <= GRAV_CONST_RESET;
         soft_radius_sq_ff <= SOFT_RADIUS_SQ_RESET;
      end else begin
         grav_const_ff     <= grav_const_in;
         soft_radius_sq_ff <= soft_radius_sq_in;
      end
   end

   // Queue between the front end, which forms the differences and classifies the
   // request, and the back end, which runs the force arithmetic.
   logic               q_valid, q_pop;
   logic [POS_WIDTH:0] q_ad_x, q_ad_y, q_ad_z;
   logic [2:0]         q_neg;
   logic [MASS_WIDTH-1:0] q_mass;
   gpa_flags_type      q_flags;

   gpa_front #(.POS_WIDTH(POS_WIDTH)) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_target_x       (req_target_x),
      .req_target_y       (req_target_y),
      .req_target_z       (req_target_z),
      .req_source_x       (req_source_x),
      .req_source_y       (req_source_y),
      .req_source_z       (req_source_z),
      .req_source_mass    (req_source_mass),
      .req_source_present (req_source_present),
      .req_is_self        (req_is_self),
      .req_last_pair      (req_last_pair),
      .q_valid            (q_valid),
      .q_pop              (q_pop),
      .q_ad_x             (q_ad_x),
      .q_ad_y             (q_ad_y),
      .q_ad_z             (q_ad_z),
      .q_neg              (q_neg),
      .q_mass             (q_mass),
      .q_flags            (q_flags)
   );

   gpa_back #(.POS_WIDTH(POS_WIDTH), .ACC_WIDTH(ACC_WIDTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .grav_const     (grav_const_ff),
      .soft_radius_sq (soft_radius_sq_ff),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_ad_x         (q_ad_x),
      .q_ad_y         (q_ad_y),
      .q_ad_z         (q_ad_z),
      .q_neg          (q_neg),
      .q_mass         (q_mass),
      .q_flags        (q_flags),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_accel_x    (rsp_accel_x),
      .rsp_accel_y    (rsp_accel_y),
      .rsp_accel_z    (rsp_accel_z),
      .rsp_saturated  (rsp_saturated)
   );

   // The back end only takes a request that the queue actually holds.
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("back end popped an empty queue");

   // A full queue must present an entry to the back end.
   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> q_valid)
      else $error("queue refuses requests while empty");

   // No result survives a reset.
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

### src/gpa_front.sv
module gpa_front import gpa_pkg::*; #(
   parameter int unsigned POS_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [POS_WIDTH-1:0] req_target_x,
   input  logic signed [POS_WIDTH-1:0] req_target_y,
   input  logic signed [POS_WIDTH-1:0] req_target_z,
   input  logic signed [POS_WIDTH-1:0] req_source_x,
   input  logic signed [POS_WIDTH-1:0] req_source_y,
   input  logic signed [POS_WIDTH-1:0] req_source_z,
   input  logic [MASS_WIDTH-1:0]       req_source_mass,
   input  logic                        req_source_present,
   input  logic                        req_is_self,
   input  logic                        req_last_pair,
   output logic                        q_valid,
   input  logic                        q_pop,
   output logic [POS_WIDTH:0]          q_ad_x,
   output logic [POS_WIDTH:0]          q_ad_y,
   output logic [POS_WIDTH:0]          q_ad_z,
   output logic [2:0]                  q_neg,
   output logic [MASS_WIDTH-1:0]       q_mass,
   output gpa_flags_type               q_flags
);

   localparam int unsigned AD_W  = POS_WIDTH + 1;
   localparam int unsigned ENT_W = 2 + MASS_WIDTH + 3 + 3 * AD_W;

   logic signed [AD_W-1:0] d_x, d_y, d_z;
   logic [AD_W-1:0]        ad_x, ad_y, ad_z;
   gpa_flags_type          flags;
   logic                   push;

   logic [ENT_W-1:0] ent_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   // Differences are one bit wider than the positions, so they are exact.
   assign d_x = AD_W'(req_target_x) - AD_W'(req_source_x);
   assign d_y = AD_W'(req_target_y) - AD_W'(req_source_y);
   assign d_z = AD_W'(req_target_z) - AD_W'(req_source_z);

   assign ad_x = d_x[AD_W-1] ? AD_W'(-d_x) : AD_W'(d_x);
   assign ad_y = d_y[AD_W-1] ? AD_W'(-d_y) : AD_W'(d_y);
   assign ad_z = d_z[AD_W-1] ? AD_W'(-d_z) : AD_W'(d_z);

   assign flags.active = req_source_present & ~req_is_self;
   assign flags.last   = req_last_pair;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid & req_ready;
   assign q_valid   = (count_ff != 2'd0);

   assign {q_flags, q_mass, q_neg, q_ad_z, q_ad_y, q_ad_x} = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= {flags, req_source_mass,
                               d_z[AD_W-1], d_y[AD_W-1], d_x[AD_W-1],
                               ad_z, ad_y, ad_x};
      end
   end

endmodule

### src/gpa_back.sv
module gpa_back import gpa_pkg::*; #(
   parameter int unsigned POS_WIDTH = 32,
   parameter int unsigned ACC_WIDTH = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [CSR_WIDTH-1:0]        grav_const,
   input  logic [CSR_WIDTH-1:0]        soft_radius_sq,
   input  logic                        q_valid,
   output logic                        q_pop,
   input  logic [POS_WIDTH:0]          q_ad_x,
   input  logic [POS_WIDTH:0]          q_ad_y,
   input  logic [POS_WIDTH:0]          q_ad_z,
   input  logic [2:0]                  q_neg,
   input  logic [MASS_WIDTH-1:0]       q_mass,
   input  gpa_flags_type               q_flags,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [ACC_WIDTH-1:0] rsp_accel_x,
   output logic signed [ACC_WIDTH-1:0] rsp_accel_y,
   output logic signed [ACC_WIDTH-1:0] rsp_accel_z,
   output logic                        rsp_saturated
);

   localparam int unsigned AD_W  = POS_WIDTH + 1;
   localparam int unsigned R2_W  = 2 * POS_WIDTH + 2;
   localparam int unsigned RM_W  = R2_W + 1;
   localparam int unsigned SQ_W  = POS_WIDTH + 4;
   localparam int unsigned GN_W  = AD_W + GDIV_FRAC;
   localparam int unsigned DN_W  = (GN_W > PROD_WIDTH) ? GN_W : PROD_WIDTH;
   localparam int unsigned CNT_W = $clog2(DN_W + 1);
   localparam logic signed [ACC_WIDTH-1:0] MAXV = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] MINV = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   gpa_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       axis_ff, axis_in;
   logic [AD_W-1:0]  ad_ff [3];
   logic [AD_W-1:0]  ad_in [3];
   logic [2:0]       neg_ff, neg_in;
   logic [MASS_WIDTH-1:0] mass_ff, mass_in;
   logic             last_ff, last_in;

   logic [MUL_WIDTH-1:0]  mul_a_ff, mul_a_in, acc_ff, acc_in;
   logic [MUL_BWIDTH-1:0] mul_b_ff, mul_b_in;
   logic [R2_W-1:0]  r2_ff, r2_in, sqs_ff, sqs_in, den_ff, den_in;
   logic [AD_W-1:0]  root_ff, root_in;
   logic [SQ_W-1:0]  sqr_ff, sqr_in;
   logic [Q_WIDTH-1:0] q_ff, q_in;
   logic [DN_W-1:0]  num_ff, num_in, quo_ff, quo_in;
   logic [RM_W-1:0]  rem_ff, rem_in;

   logic signed [ACC_WIDTH-1:0] sum_ff [3];
   logic signed [ACC_WIDTH-1:0] sum_in [3];
   logic clip_ff, clip_in;

   logic rsp_valid_ff, rsp_valid_in, rsp_sat_ff, rsp_sat_in;
   logic signed [ACC_WIDTH-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;

   // Step results of the shared units.
   logic [MUL_WIDTH-1:0]  mul_acc_nx;
   logic [SQ_W-1:0]       sq_cur, sq_trial;
   logic                  sq_ge;
   logic [RM_W-1:0]       dv_cur;
   logic                  dv_ge;
   logic [MUL_WIDTH-1:0]  thr;
   logic [1:0]            axis_nx;
   logic [PROD_WIDTH-1:0] mag;
   logic                  mag_big;
   logic signed [ACC_WIDTH-1:0] term, sum_old;
   logic signed [ACC_WIDTH:0]   sum_ext;
   logic                        sum_ov;
   logic signed [ACC_WIDTH-1:0] sum_new;

   assign mul_acc_nx = acc_ff + (mul_b_ff[0] ? mul_a_ff : '0);

   assign sq_cur   = {sqr_ff[SQ_W-3:0], sqs_ff[R2_W-1 -: 2]};
   assign sq_trial = SQ_W'({root_ff, 2'b01});
   assign sq_ge    = (sq_cur >= sq_trial);

   assign dv_cur = {rem_ff[RM_W-2:0], num_ff[DN_W-1]};
   assign dv_ge  = (dv_cur >= RM_W'(den_ff));

   assign thr     = MUL_WIDTH'({soft_radius_sq, {SOFT_SHIFT{1'b0}}});
   assign axis_nx = axis_ff + 2'd1;

   // Clip the magnitude, apply the sign opposite to the difference, then add with saturation.
   assign mag     = quo_ff[PROD_WIDTH-1:0];
   assign mag_big = |mag[PROD_WIDTH-1:ACC_WIDTH-1];
   assign sum_old = sum_ff[axis_ff];
   always_comb begin
      if (neg_ff[axis_ff]) begin
         term = mag_big ? MAXV : ACC_WIDTH'(mag);
      end else begin
         term = mag_big ? MINV : -ACC_WIDTH'(mag);
      end
   end
   assign sum_ext = {sum_old[ACC_WIDTH-1], sum_old} + {term[ACC_WIDTH-1], term};
   assign sum_ov  = (sum_ext[ACC_WIDTH] != sum_ext[ACC_WIDTH-1]);
   assign sum_new = sum_ov ? (sum_ext[ACC_WIDTH] ? MINV : MAXV) : sum_ext[ACC_WIDTH-1:0];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff - CNT_W'(1);
      axis_in  = axis_ff;
      ad_in    = ad_ff;
      neg_in   = neg_ff;
      mass_in  = mass_ff;
      last_in  = last_ff;
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      acc_in   = acc_ff;
      r2_in    = r2_ff;
      sqs_in   = sqs_ff;
      sqr_in   = sqr_ff;
      root_in  = root_ff;
      q_in     = q_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      sum_in   = sum_ff;
      clip_in  = clip_ff;
      q_pop    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_x_in   = rsp_x_ff;
      rsp_y_in   = rsp_y_ff;
      rsp_z_in   = rsp_z_ff;
      rsp_sat_in = rsp_sat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               ad_in[0] = q_ad_x;
               ad_in[1] = q_ad_y;
               ad_in[2] = q_ad_z;
               neg_in  = q_neg;
               mass_in = q_mass;
               last_in = q_flags.last;
               if (q_flags.active) begin
                  state_in = ST_SQ;
                  axis_in  = 2'd0;
                  cnt_in   = CNT_W'(AD_W);
                  mul_a_in = MUL_WIDTH'(q_ad_x);
                  mul_b_in = MUL_BWIDTH'(q_ad_x);
                  acc_in   = '0;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_SQ: begin
            // The three squares accumulate into one sum.
            acc_in   = mul_acc_nx;
            mul_a_in = mul_a_ff << 1;
            mul_b_in = mul_b_ff >> 1;
            if (cnt_ff == CNT_W'(1)) begin
               if (axis_ff == 2'd2) begin
                  state_in = ST_CMP;
               end else begin
                  axis_in  = axis_nx;
                  cnt_in   = CNT_W'(AD_W);
                  mul_a_in = MUL_WIDTH'(ad_ff[axis_nx]);
                  mul_b_in = MUL_BWIDTH'(ad_ff[axis_nx]);
               end
            end
         end
         ST_CMP: begin
            r2_in = acc_ff[R2_W-1:0];
            if (acc_ff > thr) begin
               state_in = ST_SQRT;
               sqs_in   = acc_ff[R2_W-1:0];
               sqr_in   = '0;
               root_in  = '0;
               cnt_in   = CNT_W'(AD_W);
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_SQRT: begin
            sqs_in  = sqs_ff << 2;
            sqr_in  = sq_ge ? (sq_cur - sq_trial) : sq_cur;
            root_in = {root_ff[AD_W-2:0], sq_ge};
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_QMUL;
               mul_a_in = MUL_WIDTH'(grav_const);
               mul_b_in = MUL_BWIDTH'(mass_ff);
               acc_in   = '0;
               cnt_in   = CNT_W'(MASS_WIDTH);
            end
         end
         ST_QMUL: begin
            acc_in   = mul_acc_nx;
            mul_a_in = mul_a_ff << 1;
            mul_b_in = mul_b_ff >> 1;
            if (cnt_ff == CNT_W'(1)) begin
               q_in     = mul_acc_nx[Q_WIDTH-1:0];
               state_in = ST_AXIS;
               axis_in  = 2'd0;
            end
         end
         ST_AXIS: begin
            if (ad_ff[axis_ff] == '0) begin
               // No difference on this axis, so no term.
               if (axis_ff == 2'd2) begin
                  state_in = ST_FIN;
               end else begin
                  axis_in = axis_nx;
               end
            end else begin
               state_in = ST_GDIV;
               num_in   = DN_W'(ad_ff[axis_ff]) << (DN_W - AD_W);
               den_in   = R2_W'(root_ff);
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = CNT_W'(GN_W);
            end
         end
         ST_GDIV, ST_MDIV: begin
            num_in = num_ff << 1;
            rem_in = dv_ge ? (dv_cur - RM_W'(den_ff)) : dv_cur;
            quo_in = {quo_ff[DN_W-2:0], dv_ge};
            if (cnt_ff == CNT_W'(1)) begin
               if (state_ff == ST_GDIV) begin
                  state_in = ST_PMUL;
                  mul_a_in = MUL_WIDTH'(q_ff);
                  mul_b_in = MUL_BWIDTH'(quo_in[G_WIDTH-1:0]);
                  acc_in   = '0;
                  cnt_in   = CNT_W'(G_WIDTH);
               end else begin
                  state_in = ST_ACC;
               end
            end
         end
         ST_PMUL: begin
            acc_in   = mul_acc_nx;
            mul_a_in = mul_a_ff << 1;
            mul_b_in = mul_b_ff >> 1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_MDIV;
               num_in   = DN_W'(mul_acc_nx[PROD_SHIFT+PROD_WIDTH-1:PROD_SHIFT])
                          << (DN_W - PROD_WIDTH);
               den_in   = r2_ff;
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = CNT_W'(PROD_WIDTH);
            end
         end
         ST_ACC: begin
            sum_in[axis_ff] = sum_new;
            clip_in = clip_ff | mag_big | sum_ov;
            if (axis_ff == 2'd2) begin
               state_in = ST_FIN;
            end else begin
               axis_in  = axis_nx;
               state_in = ST_AXIS;
            end
         end
         ST_FIN: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = sum_ff[0];
               rsp_y_in     = sum_ff[1];
               rsp_z_in     = sum_ff[2];
               rsp_sat_in   = clip_ff;
               sum_in[0]    = '0;
               sum_in[1]    = '0;
               sum_in[2]    = '0;
               clip_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff[0]    <= '0;
         sum_ff[1]    <= '0;
         sum_ff[2]    <= '0;
         clip_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         clip_ff      <= clip_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      axis_ff  <= axis_in;
      ad_ff    <= ad_in;
      neg_ff   <= neg_in;
      mass_ff  <= mass_in;
      last_ff  <= last_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      acc_ff   <= acc_in;
      r2_ff    <= r2_in;
      sqs_ff   <= sqs_in;
      sqr_ff   <= sqr_in;
      root_ff  <= root_in;
      q_ff     <= q_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_z_ff   <= rsp_z_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accel_x   = rsp_x_ff;
   assign rsp_accel_y   = rsp_y_ff;
   assign rsp_accel_z   = rsp_z_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

### sim/tb_gravity_pair_accel_accumulator.sv
`timescale 1ns / 100ps

module tb_gravity_pair_accel_accumulator;
   import gpa_pkg::*;

   // Widths of the block as it is built here.
   localparam int unsigned POS_W = 32;
   localparam int unsigned ACC_W = 48;

   // Largest and smallest value of a Q24.24 sum.
   localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
   localparam longint ACC_MIN = -ACC_MAX - 1;

   // This limit covers any single contributing pair, the long receiver hold and a full
   // queue several times over.
   localparam int unsigned STALL_LIMIT = 40000;
   // Up to three pairs without a result can still be in the block after the
   // last result: two in the queue and one in the back end.
   localparam int unsigned DRAIN_CYCLES = 4000;
   localparam int unsigned LONG_HOLD = 4000;

   typedef struct {
      logic signed [POS_W-1:0] tx, ty, tz, sx, sy, sz;
      logic [MASS_WIDTH-1:0] mass;
      logic present, self_pair, last;
   } pair_type;

   typedef struct {
      logic signed [ACC_W-1:0] ax, ay, az;
      logic sat;
   } accel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [POS_W-1:0] req_target_x = '0, req_target_y = '0, req_target_z = '0;
   logic signed [POS_W-1:0] req_source_x = '0, req_source_y = '0, req_source_z = '0;
   logic [MASS_WIDTH-1:0] req_source_mass = '0;
   logic req_source_present = 1'b0, req_is_self = 1'b0, req_last_pair = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [ACC_W-1:0] rsp_accel_x, rsp_accel_y, rsp_accel_z;
   logic rsp_saturated;
   logic csr_we = 1'b0;
   logic csr_index = CSR_GRAV_CONST;
   logic [CSR_WIDTH-1:0] csr_wdata = '0;

   // Pairs waiting to be offered, and target sums waiting to come back.
   pair_type pending_pairs[$];
   accel_type expected_accels[$];

   // The testbench's own copy of the registers and the running sums.
   logic [CSR_WIDTH-1:0] grav_g = GRAV_CONST_RESET;
   logic [CSR_WIDTH-1:0] cutoff_sq = SOFT_RADIUS_SQ_RESET;
   longint run_x = 0, run_y = 0, run_z = 0;
   bit run_clip = 1'b0;

   int errors = 0;
   bit hold_go = 1'b0;

   gravity_pair_accel_accumulator #(
      .POS_WIDTH(POS_W),
      .ACC_WIDTH(ACC_W)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_target_x      (req_target_x),
      .req_target_y      (req_target_y),
      .req_target_z      (req_target_z),
      .req_source_x      (req_source_x),
      .req_source_y      (req_source_y),
      .req_source_z      (req_source_z),
      .req_source_mass   (req_source_mass),
      .req_source_present(req_source_present),
      .req_is_self       (req_is_self),
      .req_last_pair     (req_last_pair),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accel_x       (rsp_accel_x),
      .rsp_accel_y       (rsp_accel_y),
      .rsp_accel_z       (rsp_accel_z),
      .rsp_saturated     (rsp_saturated),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #4 clock = ~clock;

   // Integer square root, rounded down, of an unsigned value of up to 128 bits.
   function automatic logic [63:0] floor_sqrt(logic [127:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if ({64'd0, trial} * {64'd0, trial} <= v) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // One axis of -G*m*d/r^3 in Q24.24. The magnitude is truncated before the sign
   // is applied, and a magnitude beyond the sum range is clipped and flagged.
   function automatic longint axis_accel(longint d, logic [63:0] gm, logic [127:0] r2,
                                         logic [63:0] r, inout bit clip);
      logic [127:0] ad, unit, prod, mag;
      if (d == 0) begin
         return 0;
      end
      ad = (d < 0) ? 128'(-d) : 128'(d);
      unit = (ad << GDIV_FRAC) / {64'd0, r};
      prod = ({64'd0, gm} * unit) >> PROD_SHIFT;
      mag = prod / r2;
      if (mag > 128'(ACC_MAX)) begin
         clip = 1'b1;
         return (d > 0) ? ACC_MIN : ACC_MAX;
      end
      return (d > 0) ? -longint'(mag[63:0]) : longint'(mag[63:0]);
   endfunction

   function automatic longint clamped_sum(longint s, longint t, inout bit clip);
      longint v;
      v = s + t;
      if (v > ACC_MAX) begin
         clip = 1'b1;
         return ACC_MAX;
      end
      if (v < ACC_MIN) begin
         clip = 1'b1;
         return ACC_MIN;
      end
      return v;
   endfunction

   // Folds one accepted pair into the running sums and, on the last pair of a
   // target, queues the sums that the block must return.
   task automatic accumulate_pair(pair_type p);
      longint dx, dy, dz;
      logic [127:0] r2, thr, ux, uy, uz;
      logic [63:0] r, gm;
      longint tx, ty, tz;
      accel_type a;
      if (p.present && !p.self_pair) begin
         dx = longint'(p.tx) - longint'(p.sx);
         dy = longint'(p.ty) - longint'(p.sy);
         dz = longint'(p.tz) - longint'(p.sz);
         // Squares of magnitudes up to 2^32 do not fit a signed 64-bit value.
         ux = (dx < 0) ? 128'(-dx) : 128'(dx);
         uy = (dy < 0) ? 128'(-dy) : 128'(dy);
         uz = (dz < 0) ? 128'(-dz) : 128'(dz);
         r2 = ux * ux + uy * uy + uz * uz;
         thr = 128'(cutoff_sq) << SOFT_SHIFT;
         if (r2 > thr) begin
            r = floor_sqrt(r2);
            gm = 64'(grav_g) * 64'(p.mass);
            tx = axis_accel(dx, gm, r2, r, run_clip);
            ty = axis_accel(dy, gm, r2, r, run_clip);
            tz = axis_accel(dz, gm, r2, r, run_clip);
            run_x = clamped_sum(run_x, tx, run_clip);
            run_y = clamped_sum(run_y, ty, run_clip);
            run_z = clamped_sum(run_z, tz, run_clip);
         end
      end
      if (p.last) begin
         a.ax = run_x[ACC_W-1:0];
         a.ay = run_y[ACC_W-1:0];
         a.az = run_z[ACC_W-1:0];
         a.sat = run_clip;
         expected_accels.push_back(a);
         run_x = 0;
         run_y = 0;
         run_z = 0;
         run_clip = 1'b0;
      end
   endtask

   // Driver. The sender offers requests in bursts of random length separated by
   // random gaps, and a request once offered is held until it is taken.
   int burst_left = 1;
   int gap_left = 0;
   always @(posedge clock) begin
      pair_type p, nx;
      bit fire;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         fire = req_valid && req_ready;
         if (fire) begin
            p.tx = req_target_x; p.ty = req_target_y; p.tz = req_target_z;
            p.sx = req_source_x; p.sy = req_source_y; p.sz = req_source_z;
            p.mass = req_source_mass;
            p.present = req_source_present;
            p.self_pair = req_is_self;
            p.last = req_last_pair;
            accumulate_pair(p);
         end
         if (!req_valid || fire) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_pairs.size() != 0) begin
               nx = pending_pairs.pop_front();
               req_target_x <= nx.tx; req_target_y <= nx.ty; req_target_z <= nx.tz;
               req_source_x <= nx.sx; req_source_y <= nx.sy; req_source_z <= nx.sz;
               req_source_mass <= nx.mass;
               req_source_present <= nx.present;
               req_is_self <= nx.self_pair;
               req_last_pair <= nx.last;
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  // About half of the bursts run straight into the next one.
                  gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 20);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver. It stalls on a rotating pattern that is re-drawn every so often,
   // sometimes to all ones, and once holds off for a long stretch on request.
   logic [7:0] ready_pattern = 8'hFF;
   int pattern_age = 0;
   int hold_count = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_count = LONG_HOLD;
         end
         pattern_age++;
         if (pattern_age >= 64) begin
            pattern_age = 0;
            ready_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
         end
         ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
         if (hold_count > 0) begin
            hold_count--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ready_pattern[0] | (ready_pattern == 8'h00);
         end
      end
   end

   // Monitor: each returned target sum is checked against the oldest expectation.
   always @(posedge clock) begin
      accel_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_accels.size() == 0) begin
            $error("unexpected result: accel_x=%0d accel_y=%0d accel_z=%0d saturated=%0b",
                   rsp_accel_x, rsp_accel_y, rsp_accel_z, rsp_saturated);
            errors++;
         end else begin
            e = expected_accels.pop_front();
            if (rsp_accel_x !== e.ax) begin
               $error("accel_x: expected %0d, got %0d", e.ax, rsp_accel_x);
               errors++;
            end
            if (rsp_accel_y !== e.ay) begin
               $error("accel_y: expected %0d, got %0d", e.ay, rsp_accel_y);
               errors++;
            end
            if (rsp_accel_z !== e.az) begin
               $error("accel_z: expected %0d, got %0d", e.az, rsp_accel_z);
               errors++;
            end
            if (rsp_saturated !== e.sat) begin
               $error("saturated: expected %0b, got %0b", e.sat, rsp_saturated);
               errors++;
            end
         end
      end
   end

   // Watchdog: the run is abandoned once nothing has moved for too long.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   function automatic pair_type make_pair(logic signed [31:0] tx, logic signed [31:0] ty,
                                          logic signed [31:0] tz, logic signed [31:0] sx,
                                          logic signed [31:0] sy, logic signed [31:0] sz,
                                          logic [31:0] mass, bit present, bit self_pair,
                                          bit last);
      pair_type p;
      p.tx = tx; p.ty = ty; p.tz = tz;
      p.sx = sx; p.sy = sy; p.sz = sz;
      p.mass = mass;
      p.present = present;
      p.self_pair = self_pair;
      p.last = last;
      return p;
   endfunction

   // A random offset whose size is drawn first, so that near, far and
   // coincident pairs all turn up. The full 32-bit range is used now and then.
   function automatic logic signed [31:0] random_offset();
      int k;
      k = $urandom_range(0, 31);
      if ($urandom_range(0, 7) == 0) begin
         return 0;
      end
      return $signed($urandom) >>> (31 - k);
   endfunction

   function automatic logic [31:0] random_mass();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 32'h0001_0000);
         2: return $urandom_range(0, 32'h0100_0000);
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   // Queues whole targets: a run of sources sharing one target position that
   // ends with the last pair. A small share is left without its last pair, so
   // that the following target inherits its sums, as the block allows.
   task automatic queue_targets(int count);
      int made;
      int n;
      logic signed [31:0] tx, ty, tz;
      bit wide_range;
      pair_type p;
      made = 0;
      while (made < count) begin
         n = $urandom_range(1, 6);
         wide_range = ($urandom_range(0, 3) == 0);
         tx = $urandom; ty = $urandom; tz = $urandom;
         for (int i = 0; i < n; i++) begin
            if (wide_range) begin
               p = make_pair(tx, ty, tz, $urandom, $urandom, $urandom, random_mass(),
                             1'b1, 1'b0, 1'b0);
            end else begin
               p = make_pair(tx, ty, tz, tx - random_offset(), ty - random_offset(),
                             tz - random_offset(), random_mass(), 1'b1, 1'b0, 1'b0);
            end
            if ($urandom_range(0, 7) == 0) p.present = 1'b0;
            if ($urandom_range(0, 9) == 0) p.self_pair = 1'b1;
            p.last = (i == n - 1) && ($urandom_range(0, 15) != 0);
            pending_pairs.push_back(p);
         end
         made += n;
      end
   endtask

   // Waits until every queued request has gone in and every result has come
   // back, then lets the pairs with no result finish in the block.
   task automatic drain();
      while (pending_pairs.size() != 0 || req_valid || expected_accels.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [CSR_WIDTH-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_GRAV_CONST) begin
         grav_g = value;
      end else begin
         cutoff_sq = value;
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pairs under the reset settings (G = 1000, cutoff 1.0).
      // Extreme separation with the largest mass on every axis.
      pending_pairs.push_back(make_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
         32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF, 1, 0, 1));
      pending_pairs.push_back(make_pair(32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0,
         32'hFFFF_FFFF, 1, 0, 1));
      // A coincident pair gives nothing.
      pending_pairs.push_back(make_pair(32'sh1234_5678, -5, 7, 32'sh1234_5678, -5, 7,
         32'h0001_0000, 1, 0, 1));
      // Distance exactly on the cutoff gives nothing; one step beyond counts.
      pending_pairs.push_back(make_pair(32'sh0001_0000, 0, 0, 0, 0, 0,
         32'h0001_0000, 1, 0, 1));
      pending_pairs.push_back(make_pair(32'sh0001_0001, 0, 0, 0, 0, 0,
         32'h0001_0000, 1, 0, 1));
      pending_pairs.push_back(make_pair(0, -32'sh0001_0001, 0, 0, 0, 0,
         32'h0001_0000, 1, 0, 1));
      // A close heavy pair overflows the term itself, in both directions.
      pending_pairs.push_back(make_pair(0, 0, 32'sh0002_0000, 0, 0, 0,
         32'hFFFF_FFFF, 1, 0, 1));
      pending_pairs.push_back(make_pair(0, 0, -32'sh0002_0000, 0, 0, 0,
         32'hFFFF_FFFF, 1, 0, 1));
      // Four terms that fit on their own, summed into one target.
      for (int i = 0; i < 4; i++) begin
         pending_pairs.push_back(make_pair(32'sh0080_0000, 0, 0, 0, 0, 0,
            32'h4000_0000, 1, 0, i == 3));
      end
      // Absent and self sources change nothing but still close the target.
      pending_pairs.push_back(make_pair(32'sh0100_0000, 0, 0, 0, 0, 0,
         32'h0001_0000, 1, 0, 0));
      pending_pairs.push_back(make_pair(32'sh0100_0000, 0, 0, 0, 0, 0,
         32'hFFFF_FFFF, 0, 0, 0));
      pending_pairs.push_back(make_pair(32'sh0100_0000, 0, 0, 32'sh0100_0000, 0, 0,
         32'hFFFF_FFFF, 1, 1, 1));
      pending_pairs.push_back(make_pair(5, 6, 7, -5, -6, -7, 32'hFFFF_FFFF, 0, 1, 1));
      // Zero mass, and a mixed diagonal pair.
      pending_pairs.push_back(make_pair(32'sh0010_0000, 32'sh0010_0000, 0, 0, 0, 0,
         32'h0000_0000, 1, 0, 1));
      pending_pairs.push_back(make_pair(32'sh0003_0000, -32'sh0004_0000, 32'sh0001_8000,
         -32'sh0002_0000, 32'sh0001_0000, 0, 32'h0003_0000, 1, 0, 1));
      drain();

      // The sender waits here for every result, then the receiver holds off
      // for a long stretch while requests keep coming, so the input backs up.
      queue_targets(40);
      drain();
      hold_go = 1'b1;
      queue_targets(60);
      drain();

      // Largest G with no cutoff: even adjacent pairs count and clip freely.
      write_csr(CSR_GRAV_CONST, 32'hFFFF_FFFF);
      write_csr(CSR_SOFT_RADIUS_SQ, 32'h0000_0000);
      pending_pairs.push_back(make_pair(1, 0, 0, 0, 0, 0, 32'h0000_0001, 1, 0, 1));
      queue_targets(60);
      drain();

      // G of zero with the widest cutoff: nothing but zeros comes back.
      write_csr(CSR_GRAV_CONST, 32'h0000_0000);
      write_csr(CSR_SOFT_RADIUS_SQ, 32'hFFFF_FFFF);
      queue_targets(40);
      drain();

      // Random settings for the rest.
      for (int ph = 0; ph < 3; ph++) begin
         write_csr(CSR_GRAV_CONST, $urandom >> $urandom_range(0, 24));
         write_csr(CSR_SOFT_RADIUS_SQ, $urandom >> $urandom_range(0, 31));
         queue_targets(60);
         drain();
      end

      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
